[rtl/aabb_pkg.sv]
// Shared types and constants for the axis-aligned box accumulator/classifier.
// Used by aabb_axis and aabb_accumulate_and_classify; depends on nothing.
package aabb_pkg;

    // Signed Q16.16 coordinate
    localparam int COORD_W = 32;
    typedef logic signed [COORD_W-1:0] coord_t;

    // Command codes carried on the input tuser
    localparam int CMD_W = 3;
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR            = 3'd0,
        CMD_EXTEND_POINT     = 3'd1,
        CMD_EXTEND_BOX       = 3'd2,
        CMD_CLASSIFY_POINT   = 3'd3,
        CMD_CLASSIFY_SEGMENT = 3'd4,
        CMD_CLASSIFY_BOX     = 3'd5
    } cmd_t;

    // Relation codes returned for queries
    localparam int REL_W = 2;
    typedef enum logic [REL_W-1:0] {
        REL_NONE     = 2'd0,
        REL_POSSIBLE = 2'd1,
        REL_SOME     = 2'd2,
        REL_ALL      = 2'd3
    } rel_t;

    // Outside codes: two bits per axis, below-low in the even bit
    localparam int OC_W = 6;
    typedef logic [OC_W-1:0] outcode_t;
    localparam outcode_t OC_CROSS_X = 6'h03;
    localparam outcode_t OC_CROSS_Y = 6'h0c;
    localparam outcode_t OC_CROSS_Z = 6'h30;

    // Per-axis compare results of both input points against the stored box
    typedef struct packed {
        logic a_below;   // a < low
        logic a_above;   // high < a
        logic b_below;   // b < low
        logic b_above;   // high < b
    } axis_cmp_t;

endpackage

[rtl/aabb_axis.sv]
// One axis of the box: compares both input coordinates against the stored
// bounds and forms the grown bounds. Depends on aabb_pkg.
module aabb_axis (
    input  aabb_pkg::coord_t    a,
    input  aabb_pkg::coord_t    b,
    input  aabb_pkg::coord_t    lo,
    input  aabb_pkg::coord_t    hi,
    input  logic                box_empty,
    input  logic                use_point,   // extend by a alone
    output aabb_pkg::axis_cmp_t cmp,
    output aabb_pkg::coord_t    grow_lo,
    output aabb_pkg::coord_t    grow_hi
);

    aabb_pkg::coord_t hi_src;
    logic             hi_src_above;

    // Signed compares, shared by classification and growth
    assign cmp.a_below = (a < lo);
    assign cmp.a_above = (hi < a);
    assign cmp.b_below = (b < lo);
    assign cmp.b_above = (hi < b);

    // Grow: an empty box takes the input exactly, otherwise min/max
    assign hi_src       = use_point ? a : b;
    assign hi_src_above = use_point ? cmp.a_above : cmp.b_above;

    assign grow_lo = (box_empty || cmp.a_below) ? a : lo;
    assign grow_hi = (box_empty || hi_src_above) ? hi_src : hi;

endmodule

[rtl/aabb_accumulate_and_classify.sv]
// Axis-aligned 3-D box accumulator and classifier, top level.
// Depends on aabb_pkg and aabb_axis.
//
// Holds one box (low corner, high corner, empty flag) in signed Q16.16 and runs
// one command per transaction: clear, extend by point, extend by box, or
// classify a point, segment or box against the stored box. Every transaction
// yields exactly one result carrying the relation and the box after the step.
// Throughput is one transaction per clock while the result side is not stalled;
// an accepted transaction passes through the input register, then the
// compare/min-max stage that writes the box and the result register. The rate
// is set by the box state loop: each command reads the box left by the previous
// one. An empty box answers none to every query; command codes 6 and 7 leave
// the box unchanged and answer none.
module aabb_accumulate_and_classify (
    input  logic         aclk,
    input  logic         aresetn,
    // input transaction
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z (32 bits each)
    input  logic [2:0]   s_axis_tuser,  // cmd
    // result transaction
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata   // relation(2), is_empty_now(1), lo_x, lo_y,
                                        // lo_z, hi_x, hi_y, hi_z (32 each), 5 pad zeros
);

    localparam int W = aabb_pkg::COORD_W;

    // Input register
    logic                in_valid_reg;
    aabb_pkg::cmd_t      cmd_reg;
    aabb_pkg::coord_t    a_reg [3];
    aabb_pkg::coord_t    b_reg [3];

    // Box state; also the corner part of the result register
    aabb_pkg::coord_t    lo_reg [3];
    aabb_pkg::coord_t    hi_reg [3];
    logic                empty_reg;
    aabb_pkg::coord_t    lo_next [3];
    aabb_pkg::coord_t    hi_next [3];
    logic                empty_next;

    // Result register
    logic                m_valid_reg;
    aabb_pkg::rel_t      rel_reg;
    aabb_pkg::rel_t      rel_next;

    logic                out_free;
    logic                exec;
    logic                use_point;
    aabb_pkg::axis_cmp_t cmp [3];
    aabb_pkg::coord_t    grow_lo [3];
    aabb_pkg::coord_t    grow_hi [3];

    // Handshake: the result register frees when empty or being taken
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign exec          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign use_point     = (cmd_reg == aabb_pkg::CMD_EXTEND_POINT);

    // Input register load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            cmd_reg <= aabb_pkg::cmd_t'(s_axis_tuser);
            for (int i = 0; i < 3; i++) begin
                a_reg[i] <= s_axis_tdata[i*W +: W];
                b_reg[i] <= s_axis_tdata[(i+3)*W +: W];
            end
        end
    end

    // Per-axis compare and grow
    for (genvar g = 0; g < 3; g++) begin : g_axis
        aabb_axis u_axis (
            .a         (a_reg[g]),
            .b         (b_reg[g]),
            .lo        (lo_reg[g]),
            .hi        (hi_reg[g]),
            .box_empty (empty_reg),
            .use_point (use_point),
            .cmp       (cmp[g]),
            .grow_lo   (grow_lo[g]),
            .grow_hi   (grow_hi[g])
        );
    end

    // Classification terms
    aabb_pkg::outcode_t ca, cb, cd;
    logic               point_in, box_inside, box_overlap;
    aabb_pkg::rel_t     seg_rel;

    always_comb begin
        point_in    = 1'b1;
        box_inside  = 1'b1;
        box_overlap = 1'b1;
        ca          = '0;
        cb          = '0;
        for (int i = 0; i < 3; i++) begin
            ca[2*i]   = cmp[i].a_below;
            ca[2*i+1] = cmp[i].a_above && !cmp[i].a_below;
            cb[2*i]   = cmp[i].b_below;
            cb[2*i+1] = cmp[i].b_above && !cmp[i].b_below;
            if (cmp[i].a_below || cmp[i].a_above) point_in = 1'b0;
            if (cmp[i].a_below || cmp[i].b_above) box_inside = 1'b0;
            if (cmp[i].b_below || cmp[i].a_above) box_overlap = 1'b0;
        end
        cd = ca ^ cb;
        // Equal end points fall out as the point answer through the same codes
        if ((ca & cb) != '0) begin
            seg_rel = aabb_pkg::REL_NONE;
        end else if ((ca | cb) == '0) begin
            seg_rel = aabb_pkg::REL_ALL;
        end else if (ca == '0 || cb == '0) begin
            seg_rel = aabb_pkg::REL_SOME;
        end else if (cd == aabb_pkg::OC_CROSS_X || cd == aabb_pkg::OC_CROSS_Y ||
                     cd == aabb_pkg::OC_CROSS_Z) begin
            seg_rel = aabb_pkg::REL_SOME;
        end else begin
            seg_rel = aabb_pkg::REL_POSSIBLE;
        end
    end

    // Command decode: next box state and relation
    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        empty_next = empty_reg;
        rel_next   = aabb_pkg::REL_NONE;
        unique case (cmd_reg)
            aabb_pkg::CMD_CLEAR: begin
                for (int i = 0; i < 3; i++) begin
                    lo_next[i] = '0;
                    hi_next[i] = '0;
                end
                empty_next = 1'b1;
            end
            aabb_pkg::CMD_EXTEND_POINT, aabb_pkg::CMD_EXTEND_BOX: begin
                lo_next    = grow_lo;
                hi_next    = grow_hi;
                empty_next = 1'b0;
            end
            aabb_pkg::CMD_CLASSIFY_POINT: begin
                if (!empty_reg && point_in) rel_next = aabb_pkg::REL_ALL;
            end
            aabb_pkg::CMD_CLASSIFY_SEGMENT: begin
                if (!empty_reg) rel_next = seg_rel;
            end
            aabb_pkg::CMD_CLASSIFY_BOX: begin
                if (!empty_reg) begin
                    if (box_inside) rel_next = aabb_pkg::REL_ALL;
                    else if (box_overlap) rel_next = aabb_pkg::REL_POSSIBLE;
                end
            end
            default: begin
                rel_next = aabb_pkg::REL_NONE;
            end
        endcase
    end

    // Box state and result register; both load only on a committed transaction, and the valid flag clears once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            empty_reg   <= 1'b1;
            rel_reg     <= aabb_pkg::REL_NONE;
            for (int i = 0; i < 3; i++) begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
        end else begin
            if (exec) begin
                m_valid_reg <= 1'b1;
                empty_reg   <= empty_next;
                rel_reg     <= rel_next;
                lo_reg      <= lo_next;
                hi_reg      <= hi_next;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result packing
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, hi_reg[2], hi_reg[1], hi_reg[0],
                            lo_reg[2], lo_reg[1], lo_reg[0], empty_reg, rel_reg};

endmodule
